FILE: rtl/min_priority_queue_with_delete_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the min priority queue.
// Shared property wrappers used by the RTL files that carry assertions.
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_WITH_DELETE_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_WITH_DELETE_ASSERT_SVH

// Checked at every rising clock edge while reset is low.
`define MPQD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property violated");

// Checked at every rising clock edge, reset included.
`define MPQD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("property violated");

`endif

FILE: rtl/mpqd_pkg.sv
// ----------------------------------------------------------------------------
// Min priority queue package.
// Key type, request and status codes, and the control word of the cell row.
// ----------------------------------------------------------------------------
package mpqd_pkg;

   localparam int KEY_W    = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int GROUP_W  = 16;

   typedef logic signed [KEY_W-1:0] key_type;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

   typedef struct packed {
      logic cmp;
      logic ins;
      logic del;
   } cell_ctl_type;

endpackage

FILE: rtl/mpqd_cell.sv
// ----------------------------------------------------------------------------
// Queue cell.
// Holds one key of the sorted row and its compare flags against the request
// key; shifts toward or away from the head on insert and remove.
// ----------------------------------------------------------------------------
module mpqd_cell (
   input  logic                  clock,
   input  mpqd_pkg::cell_ctl_type ctl,
   input  mpqd_pkg::key_type     key_b,
   input  logic                  occupied,
   input  logic                  prev_lt,
   input  mpqd_pkg::key_type     prev_key,
   input  mpqd_pkg::key_type     next_key,
   output mpqd_pkg::key_type     key_q,
   output logic                  lt_q,
   output logic                  eq_q
);
   import mpqd_pkg::*;

   key_type key_ff, key_in;
   logic    lt_ff, lt_in;
   logic    eq_ff, eq_in;

   always_comb begin
      key_in = key_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      if (ctl.cmp) begin
         lt_in = occupied && (key_ff < key_b);
         eq_in = occupied && (key_ff == key_b);
      end
      if (ctl.ins && !lt_ff) begin
         key_in = prev_lt ? key_b : prev_key;
      end
      if (ctl.del && !lt_ff) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key_q = key_ff;
   assign lt_q  = lt_ff;
   assign eq_q  = eq_ff;

endmodule

FILE: rtl/mpqd_hit_tree.sv
// ----------------------------------------------------------------------------
// Match reduction.
// Registers the OR of each group of cell match flags; the found flag is
// the OR of the registered group results.
// ----------------------------------------------------------------------------
module mpqd_hit_tree #(
   parameter int CAPACITY = 256
) (
   input  logic                clock,
   input  logic [CAPACITY-1:0] hit,
   output logic                found
);
   import mpqd_pkg::*;

   localparam int NUM_GROUPS = (CAPACITY + GROUP_W - 1) / GROUP_W;

   logic [NUM_GROUPS-1:0] group_ff, group_in;

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : gen_group
      always_comb begin
         group_in[g] = 1'b0;
         for (int j = 0; j < GROUP_W; j++) begin
            if (g * GROUP_W + j < CAPACITY) begin
               group_in[g] = group_in[g] | hit[g * GROUP_W + j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   assign found = |group_ff;

endmodule

FILE: rtl/min_priority_queue_with_delete.sv
// ----------------------------------------------------------------------------
// Min priority queue with delete.
// Sorted row of key cells, smallest key at the head, with match reduction.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel (action and signed key) and each one
// gives exactly one transfer on the rsp_ channel with a status, the smallest
// stored key after the request (zero when empty) and an empty flag.
// A request is taken in an idle cycle, and no further request is taken until
// its result has been loaded into the response register. Each request runs
// in turn through the cell compare, the registered match reduction across
// the cell row, the row update and the read of the head cell, which loads
// the response register.
// A new request is taken while an earlier result still waits on rsp_; if the
// receiver stalls, the block finishes the request and holds before loading
// the response register until the waiting result is taken.
// Reset empties the queue and drops any pending result; the key cells keep
// their contents, which are unused until written.
// ----------------------------------------------------------------------------
module min_priority_queue_with_delete #(
   parameter int CAPACITY = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mpqd_pkg::ACTION_W-1:0]   req_action,
   input  logic signed [mpqd_pkg::KEY_W-1:0] req_key,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mpqd_pkg::STATUS_W-1:0]   rsp_status,
   output logic signed [mpqd_pkg::KEY_W-1:0] rsp_min_key,
   output logic                            rsp_is_empty
);
   import mpqd_pkg::*;

   `include "min_priority_queue_with_delete_assert.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_RED,
      ST_APPLY,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [ACTION_W-1:0]    op_ff, op_in;
   key_type                key_ff, key_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   key_type                rsp_min_key_ff, rsp_min_key_in;
   logic                   rsp_is_empty_ff, rsp_is_empty_in;

   cell_ctl_type           ctl;
   key_type                cell_key [CAPACITY];
   logic [CAPACITY-1:0]    cell_lt;
   logic [CAPACITY-1:0]    cell_eq;
   logic [CAPACITY-1:0]    occupied;
   logic                   found;
   logic                   full;
   logic                   rsp_free;
   logic                   ins_ok;
   logic                   del_ok;

   for (genvar i = 0; i < CAPACITY; i++) begin : gen_cell
      key_type prev_key;
      key_type next_key;
      logic    prev_lt;

      assign occupied[i] = CNT_W'(i) < count_ff;

      if (i == 0) begin : gen_head
         assign prev_key = key_ff;
         assign prev_lt  = 1'b1;
      end else begin : gen_body
         assign prev_key = cell_key[i-1];
         assign prev_lt  = cell_lt[i-1];
      end

      if (i == CAPACITY - 1) begin : gen_tail
         assign next_key = cell_key[i];
      end else begin : gen_inner
         assign next_key = cell_key[i+1];
      end

      mpqd_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .key_b    (key_ff),
         .occupied (occupied[i]),
         .prev_lt  (prev_lt),
         .prev_key (prev_key),
         .next_key (next_key),
         .key_q    (cell_key[i]),
         .lt_q     (cell_lt[i]),
         .eq_q     (cell_eq[i])
      );
   end

   mpqd_hit_tree #(
      .CAPACITY (CAPACITY)
   ) u_hit_tree (
      .clock (clock),
      .hit   (cell_eq),
      .found (found)
   );

   assign full     = count_ff == CNT_W'(CAPACITY);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign ins_ok   = (op_ff == ACT_INSERT) && !full;
   assign del_ok   = (op_ff == ACT_REMOVE) && found;

   assign ctl.cmp = state_ff == ST_CMP;
   assign ctl.ins = (state_ff == ST_APPLY) && ins_ok;
   assign ctl.del = (state_ff == ST_APPLY) && del_ok;

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      count_in        = count_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_min_key_in  = rsp_min_key_ff;
      rsp_is_empty_in = rsp_is_empty_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_action;
               key_in   = req_key;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_RED;
         end
         ST_RED: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            case (op_ff)
               ACT_INSERT: begin
                  status_in = full ? STATUS_FULL : STATUS_OK;
               end
               ACT_REMOVE: begin
                  status_in = found ? STATUS_OK : STATUS_NOT_FOUND;
               end
               default: begin
                  status_in = (count_ff == '0) ? STATUS_EMPTY : STATUS_OK;
               end
            endcase
            if (ins_ok) begin
               count_in = count_ff + CNT_W'(1);
            end else if (del_ok) begin
               count_in = count_ff - CNT_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_is_empty_in = count_ff == '0;
               rsp_min_key_in  = (count_ff == '0) ? key_type'(0) : cell_key[0];
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff           <= op_in;
      key_ff          <= key_in;
      status_ff       <= status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_min_key_ff  <= rsp_min_key_in;
      rsp_is_empty_ff <= rsp_is_empty_in;
   end

   assign req_ready    = state_ff == ST_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_min_key  = rsp_min_key_ff;
   assign rsp_is_empty = rsp_is_empty_ff;

   `MPQD_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `MPQD_ASSERT(a_count_only_in_apply, clock, reset, state_ff != ST_APPLY |=> $stable(count_ff))
   `MPQD_ASSERT(a_count_step, clock, reset, state_ff == ST_APPLY |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + CNT_W'(1) || count_ff == $past(count_ff) - CNT_W'(1)))
   `MPQD_ASSERT(a_empty_status, clock, reset, rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_is_empty)
   `MPQD_ASSERT(a_empty_min_zero, clock, reset, rsp_valid && rsp_is_empty |-> rsp_min_key == key_type'(0))
   `MPQD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> state_ff == ST_IDLE && !rsp_valid_ff)

endmodule
